### hw/rtl/gap_aware_alignment_identity_unit_macros.svh
// Assertion shorthands shared by the queue and back-end RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef GAP_AWARE_ALIGNMENT_IDENTITY_UNIT_MACROS_SVH
`define GAP_AWARE_ALIGNMENT_IDENTITY_UNIT_MACROS_SVH

// Same-cycle implication.
`define GAAI_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GAAI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gaai_pkg.sv
package gaai_pkg;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int OUT_CNT_W = 17;
    localparam int IDENT_W   = 23;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 64;

    // Default saturation point of the totals
    localparam int MAX_COLUMNS_DEF = 65536;

    // Percent times 65536, and the quotient bits the divider produces
    localparam logic [IDENT_W-1:0] IDENT_SCALE = 23'd6553600;
    localparam int DIV_STEPS = IDENT_W;

    // Register reset values
    localparam logic [CFG_W-1:0] GAP_RUN_LIMIT_RST = 8'd20;
    localparam logic [CFG_W-1:0] GAP_CODE_RST      = 8'd45;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAP_RUN_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_CODE      = 1'b1;

    // Kind of the open gap run
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_QGAP = 2'd1,
        KIND_TGAP = 2'd2
    } run_kind_t;

    // Back-end sequencer
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

endpackage

### hw/rtl/gaai_front.sv
module gaai_front #(
    parameter int MAX_COLUMNS = gaai_pkg::MAX_COLUMNS_DEF,
    parameter int CNT_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [gaai_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gaai_pkg::CFG_W-1:0]     cfg_wdata,
    // column beat
    input  logic                           col_accept,
    input  logic [gaai_pkg::CHAR_W-1:0]    query_char,
    input  logic [gaai_pkg::CHAR_W-1:0]    target_char,
    input  logic                           last_column,
    // totals to the queue
    output logic                           push,
    output logic [2*CNT_W-1:0]             push_data
);
    import gaai_pkg::*;

    localparam int SUM_W = ((CNT_W > 10) ? CNT_W : 10) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLUMNS);
    localparam logic [7:0]       RUN_MAX = 8'hFF;

    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] gap_code_reg;
    run_kind_t        kind_reg, kind_next;
    logic [7:0]       cols_reg, cols_next;
    logic [7:0]       counted_reg, counted_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] mat_reg, mat_next;

    logic       qgap, tgap, own_gap, run_open, extend, close_now;
    logic       solid, match_inc;
    logic [7:0] add_close, add_last;
    logic [SUM_W-1:0] len_sum;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= GAP_RUN_LIMIT_RST;
            gap_code_reg <= GAP_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAP_RUN_LIMIT: limit_reg    <= cfg_wdata;
                REG_GAP_CODE:      gap_code_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Column classification and run tracking
    always_comb
    begin
        qgap      = (query_char == gap_code_reg);
        tgap      = (target_char == gap_code_reg);
        run_open  = (kind_reg != KIND_NONE);
        own_gap   = (kind_reg == KIND_QGAP) ? qgap : tgap;
        extend    = run_open && own_gap;
        close_now = run_open && !own_gap;
        add_close = (close_now && (cols_reg < limit_reg)) ? counted_reg : 8'd0;
        solid     = !extend && !qgap && !tgap;
        match_inc = solid && (query_char == target_char);

        if (extend)
        begin
            kind_next    = kind_reg;
            cols_next    = (cols_reg == RUN_MAX) ? cols_reg : cols_reg + 8'd1;
            counted_next = (!(qgap && tgap) && (counted_reg != RUN_MAX))
                           ? counted_reg + 8'd1 : counted_reg;
        end
        else if (qgap && !tgap)
        begin
            kind_next    = KIND_QGAP;
            cols_next    = 8'd1;
            counted_next = 8'd1;
        end
        else if (tgap && !qgap)
        begin
            kind_next    = KIND_TGAP;
            cols_next    = 8'd1;
            counted_next = 8'd1;
        end
        else
        begin
            kind_next    = KIND_NONE;
            cols_next    = 8'd0;
            counted_next = 8'd0;
        end

        // the last column closes whatever run is still open
        add_last = (last_column && (kind_next != KIND_NONE) && (cols_next < limit_reg))
                   ? counted_next : 8'd0;

        len_sum  = SUM_W'(len_reg) + SUM_W'(add_close) + SUM_W'(add_last)
                 + SUM_W'(solid);
        len_next = (len_sum > SUM_W'(MAX_CNT)) ? MAX_CNT : len_sum[CNT_W-1:0];
        mat_next = (match_inc && (mat_reg < MAX_CNT)) ? mat_reg + CNT_W'(1) : mat_reg;
    end

    // State update; the last column hands the totals on and clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_NONE;
            cols_reg    <= 8'd0;
            counted_reg <= 8'd0;
            len_reg     <= '0;
            mat_reg     <= '0;
        end
        else if (col_accept)
        begin
            if (last_column)
            begin
                kind_reg    <= KIND_NONE;
                cols_reg    <= 8'd0;
                counted_reg <= 8'd0;
                len_reg     <= '0;
                mat_reg     <= '0;
            end
            else
            begin
                kind_reg    <= kind_next;
                cols_reg    <= cols_next;
                counted_reg <= counted_next;
                len_reg     <= len_next;
                mat_reg     <= mat_next;
            end
        end
    end

    assign push      = col_accept && last_column;
    assign push_data = {len_next, mat_next};

endmodule

### hw/rtl/gaai_queue.sv
`include "gap_aware_alignment_identity_unit_macros.svh"

module gaai_queue #(
    parameter int WIDTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import gaai_pkg::*;

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && !empty) ? 1 : 0);
        end
    end

    `GAAI_ASSERT(a_queue_count, 1'b1, count_reg <= 2'(DEPTH), "queue count beyond depth")

endmodule

### hw/rtl/gaai_back.sv
`include "gap_aware_alignment_identity_unit_macros.svh"

module gaai_back #(
    parameter int MAX_COLUMNS = gaai_pkg::MAX_COLUMNS_DEF,
    parameter int CNT_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // totals from the queue
    input  logic                          empty,
    input  logic [2*CNT_W-1:0]            pop_data,
    output logic                          pop,
    // result beat
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [gaai_pkg::OUT_CNT_W-1:0] res_matches,
    output logic [gaai_pkg::OUT_CNT_W-1:0] res_length,
    output logic [gaai_pkg::IDENT_W-1:0]   res_identity
);
    import gaai_pkg::*;

    localparam int NUM_W  = CNT_W + IDENT_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    back_state_t        state_reg;
    logic [CNT_W-1:0]   mat_reg, len_reg, rem_reg;
    logic [IDENT_W-1:0] sh_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [NUM_W-1:0]   product;
    logic [CNT_W:0]     trial, shifted;
    logic               fits, out_free;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_free = !res_valid || res_ready;
    assign product  = NUM_W'(mat_reg) * NUM_W'(IDENT_SCALE);

    // One restoring divide step: shift in a dividend bit, try the subtract
    always_comb
    begin
        shifted = {rem_reg, sh_reg[IDENT_W-1]};
        trial   = shifted - {1'b0, len_reg};
        fits    = (shifted >= {1'b0, len_reg});
    end

    // Sequencer: load, scale, divide, hand over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath; the quotient is known to fit in IDENT_W bits since matches <= length
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    mat_reg <= pop_data[CNT_W-1:0];
                    len_reg <= pop_data[2*CNT_W-1:CNT_W];
                end
            end
            ST_MUL:
            begin
                rem_reg <= product[NUM_W-1:IDENT_W];
                sh_reg  <= product[IDENT_W-1:0];
            end
            ST_DIV:
            begin
                rem_reg <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
                sh_reg  <= {sh_reg[IDENT_W-2:0], fits};
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else if ((state_reg == ST_DONE) && out_free)
            res_valid <= 1'b1;
        else if (res_ready)
            res_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_matches  <= OUT_CNT_W'(mat_reg);
            res_length   <= OUT_CNT_W'(len_reg);
            res_identity <= (len_reg == '0) ? '0 : sh_reg;
        end
    end

    `GAAI_ASSERT(a_rem_below_len, (state_reg == ST_DIV) && (len_reg != '0), rem_reg < len_reg, "divider remainder not below divisor")
    `GAAI_ASSERT_NEXT(a_mul_to_div, state_reg == ST_MUL, (state_reg == ST_DIV) && (step_reg == '0), "scale step not followed by divide")
    `GAAI_ASSERT(a_ident_range, res_valid, res_identity <= IDENT_SCALE, "identity above one hundred percent")

endmodule

### hw/rtl/gap_aware_alignment_identity_unit.sv
// Gap-aware alignment identity. Alignment columns arrive one per beat on the
// s_ side, query character in s_tdata[7:0], target character in
// s_tdata[15:8], s_tlast on the final column; the front end takes one column
// per cycle while s_tready is high. The final column's totals go through a
// two-entry queue to a back end that scales the match count by 6553600 in one
// multiply and then runs a restoring divider one quotient bit per cycle; it
// works on one alignment at a time through load, multiply, 23 divide steps
// and hand-over to the output register. Columns keep streaming while the back
// end works; s_tready drops only while the queue holds two alignments not yet
// taken by the back end, so for short alignments the back end, not the column
// stream, sets the sustained rate. Registers: index 0 is the gap
// run limit (reset 20), index 1 the gap character code (reset 45); write them
// only while the block is idle.
module gap_aware_alignment_identity_unit #(
    parameter int MAX_COLUMNS = gaai_pkg::MAX_COLUMNS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [gaai_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gaai_pkg::CFG_W-1:0]     cfg_wdata,
    // column stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gaai_pkg::S_DATA_W-1:0]  s_tdata,  // query_char, target_char
    input  logic                           s_tlast,  // last_column
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // effective_matches, effective_length, identity_fixed, zero pad
    output logic [gaai_pkg::M_DATA_W-1:0]  m_tdata
);
    import gaai_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int PAD_W = M_DATA_W - 2 * OUT_CNT_W - IDENT_W;

    logic                 col_accept;
    logic                 push, full, pop, empty;
    logic [2*CNT_W-1:0]   push_data, pop_data;
    logic [OUT_CNT_W-1:0] res_matches, res_length;
    logic [IDENT_W-1:0]   res_identity;

    assign s_tready   = !full;
    assign col_accept = s_tvalid && s_tready;

    gaai_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .col_accept  (col_accept),
        .query_char  (s_tdata[CHAR_W-1:0]),
        .target_char (s_tdata[2*CHAR_W-1:CHAR_W]),
        .last_column (s_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    gaai_queue #(
        .WIDTH (2 * CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    gaai_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_matches  (res_matches),
        .res_length   (res_length),
        .res_identity (res_identity)
    );

    assign m_tdata = {{PAD_W{1'b0}}, res_identity, res_length, res_matches};

endmodule

### tb/gap_aware_alignment_identity_unit_test.sv
`timescale 1ns / 100ps

module gap_aware_alignment_identity_unit_test;

    import gaai_pkg::*;

    // Totals and identity of one alignment, as carried by m_tdata
    typedef struct {
        logic [OUT_CNT_W-1:0] mat_cnt;
        logic [OUT_CNT_W-1:0] length;
        logic [IDENT_W-1:0]   ident;
    } identity_result_t;

    // Column counter model plus the queue of alignment results still owed
    class identity_scoreboard;
        logic [CFG_W-1:0]   run_limit;
        logic [CHAR_W-1:0]  gap_sym;
        run_kind_t          kind;
        int unsigned        run_cols;
        int unsigned        run_gaps;
        int unsigned        len_total;
        int unsigned        match_total;
        identity_result_t   owed_q[$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        columns_seen;

        function new();
            run_limit    = GAP_RUN_LIMIT_RST;
            gap_sym      = GAP_CODE_RST;
            kind         = KIND_NONE;
            run_cols     = 0;
            run_gaps     = 0;
            len_total    = 0;
            match_total  = 0;
            mismatches   = 0;
            results_seen = 0;
            columns_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_GAP_RUN_LIMIT)
                run_limit = value;
            else if (idx == REG_GAP_CODE)
                gap_sym = value;
        endfunction

        // Length saturates at the column limit
        function void add_len(int unsigned n);
            if (len_total + n > MAX_COLUMNS_DEF)
                len_total = MAX_COLUMNS_DEF;
            else
                len_total += n;
        endfunction

        // Close the open gap run; its single-gap columns count if it was short
        function void end_run();
            if (kind != KIND_NONE && run_cols < run_limit)
                add_len(run_gaps);
            kind     = KIND_NONE;
            run_cols = 0;
            run_gaps = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Accepted column beat
        function void note_column(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t, bit last);
            bit qg;
            bit tg;
            bit own;
            longint unsigned scaled;
            identity_result_t r;
            qg = (q == gap_sym);
            tg = (t == gap_sym);
            columns_seen++;
            // extend the open run or end it at a non-gap on its side
            if (kind != KIND_NONE) begin
                own = (kind == KIND_QGAP) ? qg : tg;
                if (own) begin
                    if (run_cols < 255)
                        run_cols++;
                    if (!(qg && tg) && run_gaps < 255)
                        run_gaps++;
                end
                else
                    end_run();
            end
            // column taken on its own
            if (kind == KIND_NONE) begin
                if (!qg && !tg) begin
                    add_len(1);
                    if (q == t && match_total < MAX_COLUMNS_DEF)
                        match_total++;
                end
                else if (qg && !tg) begin
                    kind     = KIND_QGAP;
                    run_cols = 1;
                    run_gaps = 1;
                end
                else if (tg && !qg) begin
                    kind     = KIND_TGAP;
                    run_cols = 1;
                    run_gaps = 1;
                end
            end
            if (last) begin
                end_run();
                scaled = 0;
                if (len_total != 0)
                    scaled = (64'(match_total) * 64'(IDENT_SCALE)) / 64'(len_total);
                r.mat_cnt = match_total[OUT_CNT_W-1:0];
                r.length  = len_total[OUT_CNT_W-1:0];
                r.ident   = scaled[IDENT_W-1:0];
                owed_q.insert(owed_q.size(), r);
                len_total   = 0;
                match_total = 0;
            end
        endfunction

        // Accepted result beat
        function void check_result(logic [M_DATA_W-1:0] d);
            identity_result_t got;
            identity_result_t exp;
            got.mat_cnt = d[OUT_CNT_W-1:0];
            got.length  = d[2*OUT_CNT_W-1:OUT_CNT_W];
            got.ident   = d[2*OUT_CNT_W+IDENT_W-1:2*OUT_CNT_W];
            results_seen++;
            if (owed_q.size() == 0) begin
                $display("%0t: result with nothing owed: match count %0d length %0d ident %0d",
                         $time, got.mat_cnt, got.length, got.ident);
                mismatches++;
                return;
            end
            exp = owed_q.pop_front();
            if (got.mat_cnt !== exp.mat_cnt) begin
                $display("%0t: effective_matches expected %0d actual %0d",
                         $time, exp.mat_cnt, got.mat_cnt);
                mismatches++;
            end
            if (got.length !== exp.length) begin
                $display("%0t: effective_length expected %0d actual %0d",
                         $time, exp.length, got.length);
                mismatches++;
            end
            if (got.ident !== exp.ident) begin
                $display("%0t: identity_fixed expected %0d actual %0d",
                         $time, exp.ident, got.ident);
                mismatches++;
            end
            if (d[M_DATA_W-1:2*OUT_CNT_W+IDENT_W] !== '0) begin
                $display("%0t: m_tdata pad expected 0 actual %h",
                         $time, d[M_DATA_W-1:2*OUT_CNT_W+IDENT_W]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    identity_scoreboard    sb;
    bit                    tx_random;
    bit                    rx_random;
    bit                    hold_req;
    int unsigned           stall_cycles;
    logic [S_DATA_W-1:0]   column_buf[$];

    gap_aware_alignment_identity_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Input back-pressure seen by the sender
    always @(posedge clk)
    begin
        if (s_tvalid && !s_tready)
            stall_cycles++;
    end

    // Result side: check accepted beats, then pick next tready
    initial
    begin
        int hold_left;
        int r;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!rx_random)
                m_tready <= 1'b1;
            else begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_tready <= 1'b1;
                else if (r < 95) begin
                    m_tready  <= 1'b0;
                    hold_left = $urandom_range(0, 2);
                end
                else begin
                    m_tready  <= 1'b0;
                    hold_left = $urandom_range(10, 60);
                end
            end
        end
    end

    // Idle cycles before a beat: mostly none, some short, a few long
    function automatic int idle_len(bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == sb.gap_sym);
        return c;
    endfunction

    function automatic void push_col(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t);
        column_buf.insert(column_buf.size(), {t, q});
    endfunction

    // Gap run lengths cluster around the current limit
    function automatic int pick_run_len();
        int r;
        int lim;
        int lo;
        r   = $urandom_range(0, 99);
        lim = int'(sb.run_limit);
        lo  = (lim > 3) ? lim - 2 : 1;
        if (r < 50)
            return $urandom_range(lo, lim + 2);
        if (r < 80)
            return $urandom_range(1, 5);
        return $urandom_range(1, 2 * lim + 3);
    endfunction

    // One random alignment of about n columns into column_buf
    function automatic void build_random(int n);
        int r;
        int len;
        logic [CHAR_W-1:0] c;
        while (column_buf.size() < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                c = plain_char();
                if ($urandom_range(0, 2) == 0)
                    push_col(c, plain_char());
                else
                    push_col(c, c);
            end
            else if (r < 85) begin
                len = pick_run_len();
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_col(sb.gap_sym, sb.gap_sym);
                    else if (r < 60)
                        push_col(sb.gap_sym, plain_char());
                    else
                        push_col(plain_char(), sb.gap_sym);
                end
            end
            else if (r < 90)
                push_col(sb.gap_sym, sb.gap_sym);
            else
                push_col(CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)));
        end
    endfunction

    // Drive one column beat; valid stays high after acceptance
    task automatic send_column(input logic [CHAR_W-1:0] q, input logic [CHAR_W-1:0] t,
                               input bit last);
        int gap;
        gap = idle_len(tx_random);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, q};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_column(q, t, last);
    endtask

    // Send column_buf as one alignment, tlast on the final column
    task automatic send_alignment();
        int n;
        n = column_buf.size();
        for (int i = 0; i < n; i++)
            send_column(column_buf[i][CHAR_W-1:0], column_buf[i][2*CHAR_W-1:CHAR_W],
                        i == n - 1);
        column_buf.delete();
    endtask

    // Drain: every owed result in, then let the back end settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] code);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAP_RUN_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_index <= REG_GAP_CODE;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(REG_GAP_RUN_LIMIT, limit);
        sb.write_reg(REG_GAP_CODE, code);
    endtask

    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) == 0)
                build_random($urandom_range(31, 60));
            else
                build_random($urandom_range(1, 30));
            sent += column_buf.size();
            send_alignment();
        end
    endtask

    // Stimulus
    initial
    begin
        logic [CHAR_W-1:0] g;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        tx_random    = 1'b0;
        rx_random    = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values
        g = GAP_CODE_RST;
        push_col(g, g);
        push_col(g, g);
        send_alignment();                       // all double gaps: length 0
        push_col(8'h00, 8'h00);
        push_col(8'hff, 8'hff);
        push_col(8'h00, 8'hff);
        push_col(8'hff, 8'h00);
        send_alignment();                       // character extremes
        push_col(8'h41, 8'h41);
        push_col(g, 8'h42);
        push_col(g, 8'h43);
        push_col(g, g);
        push_col(g, 8'h44);
        push_col(8'h45, 8'h45);
        send_alignment();                       // short query run with a double gap
        push_col(8'h41, 8'h41);
        push_col(8'h42, g);
        push_col(8'h43, g);
        send_alignment();                       // target run closed by last column
        push_col(8'h01, 8'h02);
        send_alignment();                       // single mismatch
        push_col(g, 8'h41);
        push_col(8'h42, g);
        push_col(8'h43, 8'h43);
        send_alignment();                       // query run turns into target run
        wait_idle();

        // Run past the 8-bit column counter at the largest limit
        configure(8'd255, g);
        for (int i = 0; i < 260; i++)
            push_col(g, plain_char());
        push_col(8'h01, 8'h01);
        send_alignment();
        wait_idle();

        // Zero limit: no gap column counts
        configure(8'd0, g);
        push_col(8'h03, 8'h03);
        push_col(g, 8'h04);
        push_col(8'h05, 8'h05);
        send_alignment();
        wait_idle();

        // Random phases over several register settings
        configure(8'd20, 8'd45);
        tx_random = 1'b1;
        rx_random = 1'b1;
        run_random(50);
        wait_idle();

        configure(8'd1, 8'd0);
        run_random(40);
        wait_idle();

        // Long receiver hold while the sender streams short alignments
        configure(8'd8, 8'd45);
        tx_random = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            build_random($urandom_range(1, 2));
            send_alignment();
        end
        tx_random = 1'b1;
        run_random(30);
        wait_idle();

        // No idling on either side
        configure(8'd255, 8'd255);
        tx_random = 1'b0;
        rx_random = 1'b0;
        run_random(40);
        wait_idle();

        configure(8'd0, CFG_W'($urandom_range(0, 255)));
        tx_random = 1'b1;
        rx_random = 1'b1;
        run_random(30);
        wait_idle();

        configure(CFG_W'($urandom_range(2, 40)), CFG_W'($urandom_range(0, 255)));
        run_random(40);
        wait_idle();

        $display("Covered %0d columns and %0d alignment results across the register settings;",
                 sb.columns_seen, sb.results_seen);
        $display("input back-pressure held the sender for %0d cycles, %0d mismatches.",
                 stall_cycles, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
